// ----- rtl/sdtq_pkg.sv -----
// ----------------------------------------------------------------------------
// sdtq_pkg: shared types and constants
// Widths, operation and result codes, and front/back command word.
// ----------------------------------------------------------------------------
package sdtq_pkg;

    localparam int DEPTH     = 16;
    localparam int TIME_BITS = 32;
    localparam int MAX_OUT   = 16;
    localparam int IDX_BITS  = $clog2(DEPTH);
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int MO_BITS   = $clog2(MAX_OUT + 1);
    localparam int ID_BITS   = 10;
    localparam int IN_TBITS  = 32;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_ADJUST = 2'd2,
        FUNC_TICK   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_STATUS  = 2'd0,
        KIND_EXPIRED = 2'd1,
        KIND_NONE    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_PRESENT = 2'd3
    } status_t;

    typedef logic [TIME_BITS-1:0] time_t;

    // command word passed from front to back
    typedef struct packed {
        func_t               func;
        logic [ID_BITS-1:0]  id;
        time_t               tval;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_REMOVE,
        BK_INSERT,
        BK_TICK
    } bk_state_t;

    function automatic time_t to_time(input logic [IN_TBITS-1:0] v);
        time_t r;
        r = '0;
        for (int i = 0; i < TIME_BITS; i++)
        begin
            if (i < IN_TBITS)
            begin
                r[i] = v[i];
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/sdtq_if.sv -----
// ----------------------------------------------------------------------------
// sdtq_in_if / sdtq_out_if: valid/ready channels
// Input word and result word of the timer queue.
// ----------------------------------------------------------------------------
interface sdtq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [9:0]  entry_id;
    logic [31:0] expire_time;
    logic [31:0] now_time;
    modport source (output valid, func, entry_id, expire_time, now_time, input ready);
    modport sink   (input valid, func, entry_id, expire_time, now_time, output ready);
endinterface

interface sdtq_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [9:0] timer_id;
    logic [1:0] status;
    logic       last;
    modport source (output valid, kind, timer_id, status, last, input ready);
    modport sink   (input valid, kind, timer_id, status, last, output ready);
endinterface

// ----- rtl/sdtq_front.sv -----
// ----------------------------------------------------------------------------
// sdtq_front: input stage and command queue
// Accepts words, picks the relevant time, holds up to two commands.
// ----------------------------------------------------------------------------
module sdtq_front (
    input  logic          clk,
    input  logic          rst_n,
    sdtq_in_if.sink       in_ch,
    output sdtq_pkg::cmd_t cmd,
    output logic          cmd_valid,
    input  logic          cmd_take
);
    import sdtq_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] cnt_reg;
    cmd_t       c_in;
    logic       push;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign cmd_valid   = (cnt_reg != 2'd0);
    assign cmd         = q_reg[rd_reg];

    always_comb
    begin
        c_in.func = func_t'(in_ch.func);
        c_in.id   = in_ch.entry_id;
        // tick carries now, updates carry expiry
        c_in.tval = (func_t'(in_ch.func) == FUNC_TICK) ? to_time(in_ch.now_time)
                                                        : to_time(in_ch.expire_time);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= c_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (cmd_take)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, cmd_take};
        end
    end

`ifndef ASSERT_OFF
    a_no_take_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> cmd_valid) else $error("take from empty queue");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !in_ch.ready) else $error("ready while full");
`endif
endmodule

// ----- rtl/sdtq_back.sv -----
// ----------------------------------------------------------------------------
// sdtq_back: shifting sorted store and sequencer
// Parallel compare for search, shift for insert/remove, tick drain.
// ----------------------------------------------------------------------------
module sdtq_back (
    input  logic           clk,
    input  logic           rst_n,
    input  sdtq_pkg::cmd_t cmd,
    input  logic           cmd_valid,
    output logic           cmd_take,
    sdtq_out_if.source     out_ch
);
    import sdtq_pkg::*;

    time_t              dl_reg [DEPTH];
    logic [ID_BITS-1:0] hd_reg [DEPTH];
    logic [CNT_BITS-1:0] occ_reg;
    bk_state_t          st_reg, st_next;
    cmd_t               cur_reg;
    logic [MO_BITS-1:0] n_reg;

    logic               ov_reg;
    logic [1:0]         okind_reg, ostat_reg;
    logic [ID_BITS-1:0] oid_reg;
    logic               olast_reg;

    logic [DEPTH-1:0]   hit, gt;
    logic               found;
    logic [IDX_BITS-1:0] hpos;
    logic               oslot;

    logic               do_remove, do_insert;
    logic [IDX_BITS-1:0] rm_pos;
    logic               emit;
    logic [1:0]         e_kind, e_stat;
    logic [ID_BITS-1:0] e_id;
    logic               e_last;
    logic               front_exp;

    assign oslot = !ov_reg || out_ch.ready;

    always_comb
    begin
        found = 1'b0;
        hpos  = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            hit[i] = (CNT_BITS'(i) < occ_reg) && (hd_reg[i] == cmd.id);
            gt[i]  = (CNT_BITS'(i) < occ_reg) && (cur_reg.tval > dl_reg[i]);
            if (hit[i])
            begin
                found = 1'b1;
                hpos  = IDX_BITS'(i);
            end
        end
    end

    assign front_exp = (occ_reg != '0) && (dl_reg[0] <= cur_reg.tval);

    always_comb
    begin
        st_next   = st_reg;
        cmd_take  = 1'b0;
        do_remove = 1'b0;
        do_insert = 1'b0;
        rm_pos    = hpos;
        emit      = 1'b0;
        e_kind    = KIND_STATUS;
        e_stat    = ST_OK;
        e_id      = cmd.id;
        e_last    = 1'b1;
        unique case (st_reg)
            BK_IDLE:
            begin
                if (cmd_valid && oslot)
                begin
                    cmd_take = 1'b1;
                    priority if (cmd.func == FUNC_TICK)
                    begin
                        st_next = BK_TICK;
                    end
                    else if (cmd.func == FUNC_ADD)
                    begin
                        emit = 1'b1;
                        if (found)
                        begin
                            e_stat = ST_PRESENT;
                        end
                        else if (occ_reg == CNT_BITS'(DEPTH))
                        begin
                            e_stat = ST_FULL;
                        end
                        else
                        begin
                            st_next = BK_INSERT;
                        end
                    end
                    else
                    begin
                        emit = 1'b1;
                        if (!found)
                        begin
                            e_stat = ST_ABSENT;
                        end
                        else
                        begin
                            do_remove = 1'b1;
                            if (cmd.func == FUNC_ADJUST)
                            begin
                                st_next = BK_INSERT;
                            end
                        end
                    end
                end
            end
            BK_INSERT:
            begin
                do_insert = 1'b1;
                st_next   = BK_IDLE;
            end
            BK_TICK:
            begin
                rm_pos = '0;
                if (oslot)
                begin
                    emit = 1'b1;
                    e_id = hd_reg[0];
                    if (front_exp && n_reg != MO_BITS'(MAX_OUT))
                    begin
                        do_remove = 1'b1;
                        e_kind    = KIND_EXPIRED;
                        // last when the next front cannot go too
                        e_last = (n_reg == MO_BITS'(MAX_OUT - 1)) || (occ_reg == CNT_BITS'(1))
                                 || (dl_reg[1] > cur_reg.tval);
                        if (e_last)
                        begin
                            st_next = BK_IDLE;
                        end
                    end
                    else
                    begin
                        // only reached with nothing removed
                        e_kind  = KIND_NONE;
                        e_id    = '0;
                        st_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                st_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            cur_reg <= cmd;
        end
        if (do_remove)
        begin
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                if (IDX_BITS'(i) >= rm_pos)
                begin
                    dl_reg[i] <= dl_reg[i+1];
                    hd_reg[i] <= hd_reg[i+1];
                end
            end
        end
        else if (do_insert)
        begin
            // shift the tail up, drop new entry at first non-earlier slot
            if (!gt[0])
            begin
                dl_reg[0] <= cur_reg.tval;
                hd_reg[0] <= cur_reg.id;
            end
            for (int i = 1; i < DEPTH; i++)
            begin
                if (!gt[i])
                begin
                    if (gt[i-1])
                    begin
                        dl_reg[i] <= cur_reg.tval;
                        hd_reg[i] <= cur_reg.id;
                    end
                    else
                    begin
                        dl_reg[i] <= dl_reg[i-1];
                        hd_reg[i] <= hd_reg[i-1];
                    end
                end
            end
        end
        if (emit)
        begin
            okind_reg <= e_kind;
            ostat_reg <= e_stat;
            oid_reg   <= e_id;
            olast_reg <= e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= BK_IDLE;
            occ_reg <= '0;
            n_reg   <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (do_remove)
            begin
                occ_reg <= occ_reg - CNT_BITS'(1);
            end
            else if (do_insert)
            begin
                occ_reg <= occ_reg + CNT_BITS'(1);
            end
            if (cmd_take)
            begin
                n_reg <= '0;
            end
            else if (do_remove)
            begin
                n_reg <= n_reg + MO_BITS'(1);
            end
            if (emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid    = ov_reg;
    assign out_ch.kind     = okind_reg;
    assign out_ch.status   = ostat_reg;
    assign out_ch.timer_id = oid_reg;
    assign out_ch.last     = olast_reg;

`ifndef ASSERT_OFF
    a_occ_max: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_BITS'(DEPTH)) else $error("occupancy beyond depth");
    a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
        do_insert |-> occ_reg < CNT_BITS'(DEPTH)) else $error("insert into full store");
    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> oslot) else $error("result overwrites pending word");
    a_tick_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= MO_BITS'(MAX_OUT)) else $error("tick exceeded result cap");
`endif
endmodule

// ----- rtl/sorted_deadline_timer_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_deadline_timer_queue: sorted hardware timer list
// Top level joining the input queue and the shifting timer store.
// ----------------------------------------------------------------------------
// Holds up to DEPTH timers sorted by expiry in a shifting register store with
// a parallel compare per slot. Add, delete and adjust each give one status
// word: delete and failed updates end in the idle state, a successful add or
// adjust goes on to the insert state (remove/check, then insert). Tick drains
// expired timers from the front at one result word per cycle unless the
// output stalls, at most 16 per tick; a tick with nothing expired gives one
// "none" word. A two-word command queue in front keeps the input accepting,
// until full, while the store works or the output stalls; the store's sequencer sets the rate.
module sorted_deadline_timer_queue (
    input  logic      clk,
    input  logic      rst_n,
    sdtq_in_if.sink   in_ch,
    sdtq_out_if.source out_ch
);
    import sdtq_pkg::*;

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_take;

    // classify and buffer incoming words
    sdtq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take)
    );

    // carry out commands against the sorted store
    sdtq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .out_ch    (out_ch)
    );
endmodule
